[sv/lwkd_pkg.sv]
// lwkd_pkg: shared constants, types and the symbol fold table
// used by every module of the longest k-distinct window block
// no dependencies

package lwkd_pkg;

  localparam int unsigned MAX_LEN_DEF = 4096;
  localparam int unsigned SYMBOLS_DEF = 256;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned DIST_W   = 9;
  localparam int unsigned LENGTH_W = 13;

  localparam logic [DIST_W-1:0] MAX_DISTINCT_RST = DIST_W'(1);

  localparam int unsigned FOLD_N = 1 << SYMBOL_W;

  typedef logic [FOLD_N-1:0][SYMBOL_W-1:0] fold_tbl_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } cnt_cmd_t;

  // symbol value reduced into the count table range, built by counting
  function automatic fold_tbl_t fold_table(int unsigned symbols);
    fold_tbl_t   tbl;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < FOLD_N; i++) begin
      tbl[i] = SYMBOL_W'(r);
      if (r + 1 == symbols) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tbl;
  endfunction

endpackage

[sv/lwkd_ram.sv]
// lwkd_ram: generic simple dual-port ram, one write and one registered read
// depends on lwkd_pkg for default widths

module lwkd_ram #(
  parameter int unsigned WIDTH = lwkd_pkg::SYMBOL_W,
  parameter int unsigned DEPTH = lwkd_pkg::MAX_LEN_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/lwkd_cnt_store.sv]
// lwkd_cnt_store: per-symbol count table, ram plus one valid flag per entry
// an entry without its flag reads as zero; depends on lwkd_pkg and lwkd_ram

module lwkd_cnt_store #(
  parameter int unsigned SYMBOLS = lwkd_pkg::SYMBOLS_DEF,
  parameter int unsigned CNT_W   = lwkd_pkg::LENGTH_W,
  localparam int unsigned AW     = $clog2(SYMBOLS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lwkd_pkg::cnt_cmd_t   cmd,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [CNT_W-1:0]     wr_data,
  output logic [CNT_W-1:0]     rd_data
);

  logic [SYMBOLS-1:0] vld_r;
  logic [SYMBOLS-1:0] vld_nxt;
  logic [AW-1:0]      rd_addr_r;
  logic [CNT_W-1:0]   ram_q;

  lwkd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SYMBOLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.clr) begin
      vld_nxt = '0;
    end else if (cmd.wr) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_addr_r <= rd_addr;
    end
  end

  assign rd_data = vld_r[rd_addr_r] ? ram_q : '0;

endmodule

[sv/longest_window_k_distinct_top.sv]
// longest_window_k_distinct_top: longest window with exactly k distinct bytes
// depends on lwkd_pkg, lwkd_ram, lwkd_cnt_store
//
//   channel  direction  handshake            beat
//   in_      input      in_valid / in_stall  in_symbol, in_last
//   out_     output     out_valid / out_stall out_longest_length, out_found, out_too_long
//   cfg_     input      cfg_wr_en            cfg_wr_data (max_distinct)
//
// a byte is accepted with a count read, then its count is written back; past the length limit it is only flagged
// every byte released from the window adds a step to the release walk: a history ram read,
// then a count ram read-modify-write; a last byte adds the hold state that loads the result
// reset clears the count table through its valid flags at once, no sweep
// a result waiting on out_stall holds its register; input keeps flowing
// until another last byte finds the output register still full

module longest_window_k_distinct_top #(
  parameter int unsigned MAX_LEN = lwkd_pkg::MAX_LEN_DEF,
  parameter int unsigned SYMBOLS = lwkd_pkg::SYMBOLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lwkd_pkg::SYMBOL_W-1:0] in_symbol,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lwkd_pkg::LENGTH_W-1:0] out_longest_length,
  output logic                          out_found,
  output logic                          out_too_long,
  input  logic                          cfg_wr_en,
  input  logic [lwkd_pkg::DIST_W-1:0]   cfg_wr_data
);

  localparam int unsigned POS_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned HA_W   = $clog2(MAX_LEN);
  localparam int unsigned SYM_W  = $clog2(SYMBOLS);
  localparam int unsigned DIST_W = lwkd_pkg::DIST_W;
  localparam lwkd_pkg::fold_tbl_t FOLD = lwkd_pkg::fold_table(SYMBOLS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INC    = 5'b00010,
    ST_WALK_H = 5'b00100,
    ST_WALK_C = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    ws_r, ws_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [POS_W-1:0]    best_r, best_nxt;
  logic                bv_r, bv_nxt;
  logic                ovf_r, ovf_nxt;
  logic [DIST_W-1:0]   k_r, k_nxt;
  logic                last_r, last_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [SYM_W-1:0]    old_r, old_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [lwkd_pkg::LENGTH_W-1:0] out_len_r, out_len_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_too_long_r, out_too_long_nxt;

  logic                accept;
  logic                full;
  logic                slot_free;
  logic [SYM_W-1:0]    sym_fold;
  logic                hist_we;
  logic                hist_re;
  logic [lwkd_pkg::SYMBOL_W-1:0] hist_q;
  logic [SYM_W-1:0]    old_sym;
  lwkd_pkg::cnt_cmd_t  cnt_cmd;
  logic [SYM_W-1:0]    cnt_rd_addr;
  logic [SYM_W-1:0]    cnt_wr_addr;
  logic [POS_W-1:0]    cnt_wr_data;
  logic [POS_W-1:0]    cnt_q;
  logic [POS_W-1:0]    cnt_dec;
  logic [DIST_W-1:0]   dist_inc;
  logic                fin;
  logic [DIST_W-1:0]   fin_dist;
  logic [POS_W-1:0]    fin_ws;
  logic [POS_W-1:0]    win_len;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign full      = (pos_r == POS_W'(MAX_LEN));
  assign slot_free = !out_valid_r || !out_stall;
  assign sym_fold  = SYM_W'(FOLD[in_symbol]);
  assign old_sym   = hist_q[SYM_W-1:0];
  assign hist_we   = accept && !full;
  assign dist_inc  = dist_r + DIST_W'(cnt_q == '0);
  assign cnt_dec   = (cnt_q != '0) ? cnt_q - POS_W'(1) : cnt_q;
  assign win_len   = pos_r + POS_W'(1) - fin_ws;

  lwkd_ram #(
    .WIDTH (lwkd_pkg::SYMBOL_W),
    .DEPTH (MAX_LEN)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (pos_r[HA_W-1:0]),
    .wr_data (lwkd_pkg::SYMBOL_W'(sym_fold)),
    .rd_en   (hist_re),
    .rd_addr (ws_r[HA_W-1:0]),
    .rd_data (hist_q)
  );

  lwkd_cnt_store #(
    .SYMBOLS (SYMBOLS),
    .CNT_W   (POS_W)
  ) u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cnt_cmd),
    .rd_addr (cnt_rd_addr),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_data (cnt_q)
  );

  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    ws_nxt           = ws_r;
    dist_nxt         = dist_r;
    best_nxt         = best_r;
    bv_nxt           = bv_r;
    ovf_nxt          = ovf_r;
    k_nxt            = cfg_wr_en ? cfg_wr_data : k_r;
    last_nxt         = last_r;
    sym_nxt          = sym_r;
    old_nxt          = old_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_len_nxt      = out_len_r;
    out_found_nxt    = out_found_r;
    out_too_long_nxt = out_too_long_r;
    hist_re          = 1'b0;
    cnt_cmd          = '0;
    cnt_rd_addr      = sym_fold;
    cnt_wr_addr      = sym_r;
    cnt_wr_data      = cnt_q + POS_W'(1);
    fin              = 1'b0;
    fin_dist         = dist_r;
    fin_ws           = ws_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          sym_nxt  = sym_fold;
          if (full) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_last ? ST_HOLD : ST_IDLE;
          end else begin
            cnt_cmd.rd = 1'b1;
            state_nxt  = ST_INC;
          end
        end
      end
      ST_INC: begin
        cnt_cmd.wr = 1'b1;
        if (dist_inc > k_r) begin
          dist_nxt  = dist_inc;
          hist_re   = 1'b1;
          state_nxt = ST_WALK_H;
        end else begin
          fin      = 1'b1;
          fin_dist = dist_inc;
        end
      end
      ST_WALK_H: begin
        cnt_cmd.rd  = 1'b1;
        cnt_rd_addr = old_sym;
        old_nxt     = old_sym;
        ws_nxt      = ws_r + POS_W'(1);
        state_nxt   = ST_WALK_C;
      end
      ST_WALK_C: begin
        cnt_cmd.wr  = 1'b1;
        cnt_wr_addr = old_r;
        cnt_wr_data = cnt_dec;
        if (cnt_dec == '0 || ws_r > pos_r) begin
          fin      = 1'b1;
          fin_dist = dist_r - DIST_W'(1);
        end else begin
          hist_re   = 1'b1;
          state_nxt = ST_WALK_H;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_len_nxt      = bv_r ? lwkd_pkg::LENGTH_W'(best_r) : '0;
          out_found_nxt    = bv_r;
          out_too_long_nxt = ovf_r;
          cnt_cmd.clr      = 1'b1;
          pos_nxt          = '0;
          ws_nxt           = '0;
          dist_nxt         = '0;
          best_nxt         = '0;
          bv_nxt           = 1'b0;
          ovf_nxt          = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // window bookkeeping once the byte is settled
    if (fin) begin
      dist_nxt  = fin_dist;
      pos_nxt   = pos_r + POS_W'(1);
      state_nxt = last_r ? ST_HOLD : ST_IDLE;
      if (fin_dist == k_r && (!bv_r || win_len > best_r)) begin
        best_nxt = win_len;
        bv_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      ws_r        <= '0;
      dist_r      <= '0;
      best_r      <= '0;
      bv_r        <= 1'b0;
      ovf_r       <= 1'b0;
      k_r         <= lwkd_pkg::MAX_DISTINCT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ws_r        <= ws_nxt;
      dist_r      <= dist_nxt;
      best_r      <= best_nxt;
      bv_r        <= bv_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r         <= last_nxt;
    sym_r          <= sym_nxt;
    old_r          <= old_nxt;
    out_len_r      <= out_len_nxt;
    out_found_r    <= out_found_nxt;
    out_too_long_r <= out_too_long_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_longest_length = out_len_r;
  assign out_found          = out_found_r;
  assign out_too_long       = out_too_long_r;

endmodule

[sv/lwkd_checker.sv]
// lwkd_checker: port-level assertions for longest_window_k_distinct_top
// bound to the top level below; depends on lwkd_pkg for widths

module lwkd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lwkd_pkg::LENGTH_W-1:0] out_longest_length,
  input logic                          out_found,
  input logic                          out_too_long
);

  // no window found means a zero length
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_longest_length == '0))
  else $error("length nonzero without a found window");

  // a new result leaves the block ready for the next string
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
  else $error("input stalled right after a result was loaded");

  // reset empties the result register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
  else $error("result valid after reset");

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_longest_length)
      && $stable(out_found) && $stable(out_too_long)))
  else $error("stalled result beat changed");

endmodule

bind longest_window_k_distinct_top lwkd_checker u_lwkd_checker (.*);

[test/longest_window_k_distinct_top_test.sv]
`timescale 1ns / 1ps
// longest_window_k_distinct_top_test: self-checking bench for the longest k-distinct window block
// drives byte strings with random gaps and stalls and predicts each string's result in place
// depends on lwkd_pkg and longest_window_k_distinct_top

module longest_window_k_distinct_top_test;

  localparam int unsigned MAX_LEN        = lwkd_pkg::MAX_LEN_DEF;
  localparam int unsigned SYMBOLS        = lwkd_pkg::SYMBOLS_DEF;
  localparam int unsigned SYMBOL_W       = lwkd_pkg::SYMBOL_W;
  localparam int unsigned LENGTH_W       = lwkd_pkg::LENGTH_W;
  localparam int unsigned DIST_W         = lwkd_pkg::DIST_W;
  localparam int unsigned GAP_MAX        = 18;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PHASE_BYTES    = 45;

  typedef struct {
    logic [LENGTH_W-1:0] len;
    logic                found;
    logic                too_long;
  } window_result_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [SYMBOL_W-1:0] in_symbol   = '0;
  logic                in_last     = 1'b0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [LENGTH_W-1:0] out_longest_length;
  logic                out_found;
  logic                out_too_long;
  logic                cfg_wr_en   = 1'b0;
  logic [DIST_W-1:0]   cfg_wr_data = '0;

  window_result_t expected_windows[$];
  int unsigned    mismatches      = 0;
  int unsigned    bytes_sent      = 0;
  int unsigned    windows_checked = 0;
  int unsigned    hold_request    = 0;
  bit             send_idle       = 1'b1;
  bit             recv_idle       = 1'b1;

  // predictor state
  logic [DIST_W-1:0]   k_distinct = lwkd_pkg::MAX_DISTINCT_RST;
  int unsigned         sym_count[SYMBOLS];
  logic [SYMBOL_W-1:0] seen_bytes[MAX_LEN];
  int unsigned         str_pos    = 0;
  int unsigned         win_start  = 0;
  int unsigned         n_distinct = 0;
  int unsigned         best_len   = 0;
  bit                  best_ok    = 1'b0;
  bit                  overflow   = 1'b0;

  always #5 clk = ~clk;

  longest_window_k_distinct_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_symbol          (in_symbol),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_longest_length (out_longest_length),
    .out_found          (out_found),
    .out_too_long       (out_too_long),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  function automatic void clear_string();
    for (int i = 0; i < SYMBOLS; i++) begin
      sym_count[i] = 0;
    end
    str_pos    = 0;
    win_start  = 0;
    n_distinct = 0;
    best_len   = 0;
    best_ok    = 1'b0;
    overflow   = 1'b0;
  endfunction

  function automatic void predict_window(input logic [SYMBOL_W-1:0] sym_in, input logic last);
    window_result_t      r;
    logic [SYMBOL_W-1:0] sym;
    logic [SYMBOL_W-1:0] gone;
    int unsigned         len;
    sym = SYMBOL_W'(int'(sym_in) % SYMBOLS);
    if (str_pos < MAX_LEN) begin
      seen_bytes[str_pos] = sym;
      if (sym_count[sym] == 0) begin
        n_distinct++;
      end
      sym_count[sym]++;
      if (n_distinct > k_distinct) begin
        while (win_start <= str_pos) begin
          gone = seen_bytes[win_start];
          win_start++;
          if (sym_count[gone] > 0) begin
            sym_count[gone]--;
          end
          if (sym_count[gone] == 0) begin
            break;
          end
        end
        n_distinct--;
      end
      if (n_distinct == k_distinct) begin
        len = str_pos + 1 - win_start;
        if (!best_ok || len > best_len) begin
          best_len = len;
          best_ok  = 1'b1;
        end
      end
      str_pos++;
    end else begin
      overflow = 1'b1;
    end
    if (last) begin
      r.len      = best_ok ? LENGTH_W'(best_len) : '0;
      r.found    = best_ok;
      r.too_long = overflow;
      expected_windows.push_back(r);
      clear_string();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic send_byte(input logic [SYMBOL_W-1:0] sym, input logic last);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= last;
    do @(posedge clk); while (in_stall);
    predict_window(sym, last);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_k(input logic [DIST_W-1:0] k);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    k_distinct = k;
  endtask

  // reset value of k, symbol extremes, k of two, k of zero, k of the full alphabet and k of three
  task automatic test_directed_cases();
    logic [SYMBOL_W-1:0] spread[8];
    logic [SYMBOL_W-1:0] mix[6];
    spread = '{8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1};
    mix    = '{8'd1, 8'd2, 8'd1, 8'd3, 8'd3, 8'd3};
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b1);
    drain();
    set_k(DIST_W'(2));
    foreach (mix[i]) send_byte(mix[i], i == 5);
    drain();
    set_k(DIST_W'(0));
    send_byte(8'd5, 1'b0);
    send_byte(8'd6, 1'b1);
    drain();
    set_k(DIST_W'(256));
    send_byte(8'd7, 1'b0);
    send_byte(8'd8, 1'b0);
    send_byte(8'd9, 1'b1);
    drain();
    set_k(DIST_W'(3));
    foreach (spread[i]) send_byte(spread[i], i == 7);
    drain();
  endtask

  // every byte value once in shuffled order, then a few repeats
  task automatic test_all_symbols();
    logic [SYMBOL_W-1:0] perm[SYMBOLS];
    logic [SYMBOL_W-1:0] tmp;
    int unsigned         j;
    for (int i = 0; i < SYMBOLS; i++) begin
      perm[i] = SYMBOL_W'(i);
    end
    for (int i = SYMBOLS - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    set_k(DIST_W'(256));
    for (int i = 0; i < SYMBOLS; i++) begin
      send_byte(perm[i], 1'b0);
    end
    for (int i = 0; i < 10; i++) begin
      send_byte(SYMBOL_W'($urandom_range(0, 255)), i == 9);
    end
    drain();
  endtask

  // receiver holds off while short strings keep coming, so the input stalls
  task automatic test_output_backpressure();
    int unsigned len;
    set_k(DIST_W'(1));
    send_idle    = 1'b0;
    recv_idle    = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int s = 0; s < 40; s++) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        send_byte(SYMBOL_W'($urandom_range(0, 255)), i == len - 1);
      end
    end
    drain();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // strings over random alphabets of k to k+3 bytes (at least 1, at most 256), some pure noise
  task automatic test_random_strings();
    logic [SYMBOL_W-1:0] alphabet[SYMBOLS];
    int unsigned         sent;
    int unsigned         len;
    int unsigned         alpha_n;
    int unsigned         k;
    bit                  noise;
    for (int ph = 0; ph < 8; ph++) begin
      unique case (ph)
        0: begin
          k = 0;
        end
        1: begin
          k = 256;
        end
        2: begin
          k = 1;
        end
        3: begin
          k = 255;
        end
        4: begin
          k = $urandom_range(0, 256);
        end
        default: begin
          k = $urandom_range(1, 6);
        end
      endcase
      set_k(DIST_W'(k));
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        noise     = ($urandom_range(0, 7) == 0);
        alpha_n   = k + $urandom_range(0, 3);
        if (alpha_n == 0) begin
          alpha_n = 1;
        end
        if (alpha_n > SYMBOLS) begin
          alpha_n = SYMBOLS;
        end
        for (int i = 0; i < alpha_n; i++) begin
          alphabet[i] = SYMBOL_W'($urandom_range(0, 255));
        end
        len = $urandom_range(1, alpha_n * 3 + 4);
        if (len > 60) begin
          len = 60;
        end
        for (int i = 0; i < len; i++) begin
          send_byte(noise ? SYMBOL_W'($urandom_range(0, 255))
                          : alphabet[$urandom_range(0, alpha_n - 1)], i == len - 1);
        end
        sent += len;
      end
      drain();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    window_result_t want;
    int unsigned    stall_left;
    int unsigned    hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: len %0d found %0b",
                                    out_longest_length, out_found));
        end else begin
          want = expected_windows.pop_front();
          windows_checked++;
          if (out_longest_length !== want.len) begin
            report_mismatch($sformatf("longest_length %0d, expected %0d",
                                      out_longest_length, want.len));
          end
          if (out_found !== want.found) begin
            report_mismatch($sformatf("found %b, expected %b", out_found, want.found));
          end
          if (out_too_long !== want.too_long) begin
            report_mismatch($sformatf("too_long %b, expected %b",
                                      out_too_long, want.too_long));
          end
        end
        stall_left = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL longest_window_k_distinct_top");
    $finish;
  end

  initial begin
    clear_string();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_all_symbols();
    test_output_backpressure();
    test_random_strings();
    $display("run sent %0d bytes and checked %0d string results, %0d mismatches",
             bytes_sent, windows_checked, mismatches);
    $display("k ranged 0..256 over short strings, every byte value, long output hold-off");
    if (mismatches == 0) begin
      $display("PASS longest_window_k_distinct_top");
    end else begin
      $display("FAIL longest_window_k_distinct_top");
    end
    $finish;
  end

endmodule
